// ----- rtl/mie_pkg.sv -----
// ----------------------------------------------------------------------------
// mie_pkg: shared types for the modular inverse core
// Command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package mie_pkg;

  localparam int unsigned FIELD_W = 64;

  typedef struct packed {
    logic start;      // load operand, modulus and coefficients
    logic div_start;  // load divider
    logic div_sel;    // 0: value / divisor, 1: quotient / modulus
    logic div_step;
    logic div1_done;  // keep quotient and remainder of the first division
    logic div2_done;  // keep reduced quotient
    logic mul_start;
    logic mul_step;
    logic upd;        // rotate pair and coefficients
    logic fin_wr;     // write result register
    logic fin_bad;
  } ctl_cmd_t;

  typedef struct packed {
    logic m_lt2;
    logic val_le1;
    logic div_zero;
    logic q_ge_m;
    logic cnt_last;
    logic out_free;
  } ctl_sts_t;

endpackage

// ----- rtl/mie_ctrl.sv -----
// ----------------------------------------------------------------------------
// mie_ctrl: sequencer for the modular inverse core
// Walks each Euclid round: division, reduction if q >= m, multiply, update.
// ----------------------------------------------------------------------------
module mie_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mie_pkg::ctl_sts_t sts,
  output mie_pkg::ctl_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_QCHK  = 4'd3;
  localparam logic [3:0] S_RDONE = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_UPD   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;

  logic [3:0] state_r, state_nxt;
  logic       red_r, red_nxt;
  logic       bad_r, bad_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    red_nxt   = red_r;
    bad_nxt   = bad_r;
    cmd       = '0;
    cmd.fin_bad = bad_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.m_lt2) begin
          bad_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else if (sts.val_le1) begin
          bad_nxt   = 1'b0;
          state_nxt = S_FIN;
        end else if (sts.div_zero) begin
          bad_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b0;
          red_nxt       = 1'b0;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.cnt_last) state_nxt = red_r ? S_RDONE : S_QCHK;
      end
      S_QCHK: begin
        cmd.div1_done = 1'b1;
        if (sts.q_ge_m) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          red_nxt       = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.mul_start = 1'b1;
          state_nxt     = S_MUL;
        end
      end
      S_RDONE: begin
        cmd.div2_done = 1'b1;
        cmd.mul_start = 1'b1;
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.cnt_last) state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_CHECK;
      end
      S_FIN: begin
        // hold until the result register can take the beat
        if (sts.out_free) begin
          cmd.fin_wr = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      red_r   <= 1'b0;
      bad_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      red_r   <= red_nxt;
      bad_r   <= bad_nxt;
    end
  end

  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_wr |-> sts.out_free) else $error("result written while register busy");
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && sts.cnt_last) |=> (state_r == S_QCHK || state_r == S_RDONE))
    else $error("division did not end in a check state");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> state_r == S_CHECK) else $error("start did not enter check");

endmodule

// ----- rtl/mie_dp.sv -----
// ----------------------------------------------------------------------------
// mie_dp: datapath for the modular inverse core
// Bit-serial divider, shift-and-add modular multiplier, result register.
// ----------------------------------------------------------------------------
module mie_dp #(
  parameter int unsigned WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mie_pkg::FIELD_W-1:0]   cfg_wdata,
  input  logic [mie_pkg::FIELD_W-1:0]   in_operand,
  input  mie_pkg::ctl_cmd_t             cmd,
  output mie_pkg::ctl_sts_t             sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mie_pkg::FIELD_W-1:0]   out_inverse,
  output logic                          out_not_invertible
);

  localparam int unsigned CW = $clog2(WIDTH);
  localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);
  localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] gap;
    gap = m - y;
    return (x >= gap) ? (x - gap) : (x + y);
  endfunction

  logic [WIDTH-1:0] mod_cfg_r;
  logic [WIDTH-1:0] m_r, val_r, div_r, x0_r, x1_r, q_r, r1_r;
  logic [WIDTH-1:0] dq_r, dr_r, dd_r, acc_r, mb_r;
  logic [CW-1:0]    cnt_r;
  logic [WIDTH-1:0] res_r;
  logic             bad_r, ov_r;

  logic [WIDTH:0]   sh;
  logic             ge;
  logic [WIDTH:0]   diff;
  logic [WIDTH-1:0] dbl, acc_nxt, nx;

  always_comb begin
    sh      = {dr_r, dq_r[WIDTH-1]};
    diff    = sh - {1'b0, dd_r};
    ge      = (sh >= {1'b0, dd_r});
    dbl     = add_mod(acc_r, acc_r, m_r);
    acc_nxt = mb_r[WIDTH-1] ? add_mod(dbl, q_r, m_r) : dbl;
    nx      = (x1_r >= acc_r) ? (x1_r - acc_r) : (x1_r + (m_r - acc_r));
  end

  always_comb begin
    sts.m_lt2    = (m_r < WIDTH'(2));
    sts.val_le1  = (val_r <= ONE);
    sts.div_zero = (div_r == '0);
    sts.q_ge_m   = (dq_r >= m_r);
    sts.cnt_last = (cnt_r == CNT_LAST);
    sts.out_free = !ov_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mod_cfg_r <= WIDTH'(2);
    else if (cfg_we) mod_cfg_r <= cfg_wdata[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      m_r   <= mod_cfg_r;
      val_r <= in_operand[WIDTH-1:0];
      div_r <= mod_cfg_r;
      x0_r  <= '0;
      x1_r  <= ONE;
    end
    if (cmd.div_start) begin
      dq_r  <= cmd.div_sel ? dq_r : val_r;
      dd_r  <= cmd.div_sel ? m_r : div_r;
      dr_r  <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      dq_r  <= {dq_r[WIDTH-2:0], ge};
      dr_r  <= ge ? diff[WIDTH-1:0] : sh[WIDTH-1:0];
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.div1_done) begin
      q_r  <= dq_r;
      r1_r <= dr_r;
    end
    if (cmd.div2_done) q_r <= dr_r;
    if (cmd.mul_start) begin
      acc_r <= '0;
      mb_r  <= x0_r;
      cnt_r <= '0;
    end
    if (cmd.mul_step) begin
      acc_r <= acc_nxt;
      mb_r  <= {mb_r[WIDTH-2:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.upd) begin
      val_r <= div_r;
      div_r <= r1_r;
      x1_r  <= x0_r;
      x0_r  <= nx;
    end
    if (cmd.fin_wr) begin
      res_r <= cmd.fin_bad ? '0 : x1_r;
      bad_r <= cmd.fin_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.fin_wr) ov_r <= 1'b1;
    else if (!out_stall) ov_r <= 1'b0;
  end

  assign out_valid          = ov_r;
  assign out_inverse        = mie_pkg::FIELD_W'(res_r);
  assign out_not_invertible = bad_r;

endmodule

// ----- rtl/modular_inverse_euclid_core.sv -----
// ----------------------------------------------------------------------------
// modular_inverse_euclid_core: modular inverse by extended Euclid
// Returns operand^-1 mod modulus, or a not-invertible flag.
// ----------------------------------------------------------------------------
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+-------------
//  input    | in_operand                                    | valid/stall
//  result   | out_inverse, out_not_invertible               | valid/stall
//  config   | cfg_we, cfg_wdata (modulus, reset 2)          | write enable
//
//  A round whose quotient reaches the modulus runs a second division to reduce
//  it; the bit-serial divider and the shift-and-add multiplier work one bit
//  per cycle each.
//  Reset is synchronous, active low; the modulus returns to 2.
//  A result waits in its own register, so a new operand is taken meanwhile.
// ----------------------------------------------------------------------------
module modular_inverse_euclid_core #(
  parameter int unsigned WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [mie_pkg::FIELD_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mie_pkg::FIELD_W-1:0] in_operand,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mie_pkg::FIELD_W-1:0] out_inverse,
  output logic                        out_not_invertible
);

  mie_pkg::ctl_cmd_t cmd;
  mie_pkg::ctl_sts_t sts;

  mie_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mie_dp #(.WIDTH(WIDTH)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_operand         (in_operand),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_inverse        (out_inverse),
    .out_not_invertible (out_not_invertible)
  );

endmodule

// ----- tb/sv/tb_modular_inverse_euclid_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modular_inverse_euclid_core: self-checking bench for the inverse core
// Drives a table of directed operands and then random phases, each under
// its own modulus, with random gaps on input and random stalls on output.
// Every beat is checked against its table value or the Euclid model held here.
// ----------------------------------------------------------------------------
module tb_modular_inverse_euclid_core;

  localparam int unsigned W        = mie_pkg::FIELD_W;
  localparam int unsigned IDLE_LIM = 400000;
  localparam logic [W-1:0] ONES    = '1;
  localparam logic [W-1:0] FIB93   = 64'd12200160415121876738;
  localparam logic [W-1:0] FIB92   = 64'd7540113804746346429;

  typedef struct {
    logic [W-1:0] inv;
    bit           bad;
  } inv_res_t;

  typedef struct {
    logic [W-1:0] modulus;
    logic [W-1:0] operand;
    bit           typed;
    logic [W-1:0] inv;
    bit           bad;
  } vec_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [W-1:0] cfg_wdata = '0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  logic [W-1:0] in_operand = '0;
  logic         out_valid;
  logic         out_stall = 1'b1;
  logic [W-1:0] out_inverse;
  logic         out_not_invertible;

  inv_res_t     inv_expected[$];
  logic [W-1:0] cur_modulus;
  int           err_count = 0;
  int           idle_cycles = 0;
  bit           stall_busy_mode = 1'b1;

  modular_inverse_euclid_core #(.WIDTH(W)) dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_operand(in_operand),
    .out_valid(out_valid), .out_stall(out_stall), .out_inverse(out_inverse),
    .out_not_invertible(out_not_invertible)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic inv_res_t euclid_inverse(logic [W-1:0] m, logic [W-1:0] a);
    inv_res_t     res;
    logic [W-1:0] val, dvs, q, r, x0, x1, p;
    logic [2*W-1:0] prod;
    res.inv = '0;
    res.bad = 1'b1;
    if (m < 2) return res;
    val = a;
    dvs = m;
    x0 = '0;
    x1 = W'(1);
    while (val > 1) begin
      if (dvs == 0) return res;
      q = val / dvs;
      r = val % dvs;
      val = dvs;
      dvs = r;
      prod = {{W{1'b0}}, q % m} * {{W{1'b0}}, x0};
      p = W'(prod % {{W{1'b0}}, m});
      p = (x1 >= p) ? x1 - p : x1 + (m - p);
      x1 = x0;
      x0 = p;
    end
    res.inv = x1;
    res.bad = 1'b0;
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    err_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 250);
  endfunction

  function automatic logic [W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // drop valid, hold off until the core is idle, then write the modulus
  task automatic set_modulus(logic [W-1:0] m);
    in_valid <= 1'b0;
    wait (inv_expected.size() == 0);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_modulus = m;
  endtask

  task automatic send_operand(logic [W-1:0] a, bit typed, inv_res_t want);
    int g;
    in_valid   <= 1'b1;
    in_operand <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    inv_expected.push_back(typed ? want : euclid_inverse(cur_modulus, a));
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // result side: stall pattern, checks and the idle watchdog
  always @(posedge clk) begin
    inv_res_t want;
    bit       moved;
    moved = 1'b0;
    if (rst_n && in_valid && !in_stall) moved = 1'b1;
    if (rst_n && out_valid && !out_stall) begin
      moved = 1'b1;
      if (inv_expected.size() == 0) begin
        flag_mismatch("unexpected beat", out_inverse, '0);
      end else begin
        want = inv_expected.pop_front();
        if (out_not_invertible !== want.bad)
          flag_mismatch("not_invertible", W'(out_not_invertible), W'(want.bad));
        if (out_inverse !== want.inv)
          flag_mismatch("inverse", out_inverse, want.inv);
      end
    end
    if ($urandom_range(0, 199) == 0) stall_busy_mode <= ~stall_busy_mode;
    if (!rst_n) out_stall <= 1'b1;
    else if (!stall_busy_mode) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 35);
    idle_cycles <= moved ? 0 : idle_cycles + 1;
    if (rst_n && idle_cycles > IDLE_LIM) begin
      $display("tb_modular_inverse_euclid_core: FAIL");
      $finish;
    end
  end

  initial begin
    vec_t     vecs[$];
    inv_res_t want;
    logic [W-1:0] m, a;
    int       n_items, phase_len;

    vecs = '{
      '{64'd2,  64'd0,  1'b1, 64'd1, 1'b0},
      '{64'd2,  64'd1,  1'b1, 64'd1, 1'b0},
      '{64'd2,  64'd2,  1'b1, 64'd0, 1'b1},
      '{64'd2,  64'd3,  1'b0, 64'd0, 1'b0},
      '{64'd0,  64'd0,  1'b1, 64'd0, 1'b1},
      '{64'd0,  64'd1,  1'b1, 64'd0, 1'b1},
      '{64'd1,  64'd5,  1'b1, 64'd0, 1'b1},
      '{64'd1,  64'd1,  1'b1, 64'd0, 1'b1},
      '{ONES,   64'd0,  1'b1, 64'd1, 1'b0},
      '{ONES,   64'd1,  1'b1, 64'd1, 1'b0},
      '{ONES,   ONES,   1'b1, 64'd0, 1'b1},
      '{ONES,   ONES-1, 1'b1, ONES-1, 1'b0},
      '{ONES,   64'd3,  1'b1, 64'd0, 1'b1},
      '{ONES,   64'h8000_0000_0000_0000, 1'b0, 64'd0, 1'b0},
      '{64'd97, 64'd96, 1'b1, 64'd96, 1'b0},
      '{64'd97, 64'd194, 1'b1, 64'd0, 1'b1},
      '{64'd97, 64'd98, 1'b1, 64'd1, 1'b0},
      '{64'd97, ONES,   1'b0, 64'd0, 1'b0},
      '{FIB93,  FIB92,  1'b0, 64'd0, 1'b0},
      '{FIB93,  64'h5555_5555_5555_5555, 1'b0, 64'd0, 1'b0},
      '{64'h8000_0000_0000_0000, 64'd3, 1'b0, 64'd0, 1'b0},
      '{64'h8000_0000_0000_0000, 64'd2, 1'b1, 64'd0, 1'b1}
    };

    cur_modulus = 64'd2;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vecs[i]) begin
      if (vecs[i].modulus != cur_modulus) set_modulus(vecs[i].modulus);
      want.inv = vecs[i].inv;
      want.bad = vecs[i].bad;
      send_operand(vecs[i].operand, vecs[i].typed, want);
    end

    // random phases: mostly small moduli, a few wide or out of range
    n_items = 0;
    while (n_items < 260) begin
      case ($urandom_range(0, 9))
        0:       m = rand64();
        1:       m = {32'd0, $urandom()};
        2:       m = W'($urandom_range(0, 1));
        3:       m = 64'd2;
        default: m = W'($urandom_range(3, 65535));
      endcase
      set_modulus(m);
      phase_len = $urandom_range(10, 30);
      repeat (phase_len) begin
        case ($urandom_range(0, 9))
          0:       a = W'($urandom_range(0, 1));
          1:       a = m * W'($urandom_range(1, 50));
          2:       a = W'($urandom_range(2, 1000));
          3:       a = m - 1;
          default: a = rand64();
        endcase
        send_operand(a, 1'b0, want);
        n_items++;
      end
    end
    in_valid <= 1'b0;

    wait (inv_expected.size() == 0);
    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_modular_inverse_euclid_core: PASS");
    end else begin
      $display("tb_modular_inverse_euclid_core: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mie_pkg.sv
rtl/mie_ctrl.sv
rtl/mie_dp.sv
rtl/modular_inverse_euclid_core.sv
tb/sv/tb_modular_inverse_euclid_core.sv
